>>> rtl/wsfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the websocket frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   // result queue depth; an accepted byte can push up to two results
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // frame type codes reported on the status item
   localparam logic [2:0] TYPE_CONT   = 3'd0;
   localparam logic [2:0] TYPE_TEXT   = 3'd1;
   localparam logic [2:0] TYPE_BINARY = 3'd2;
   localparam logic [2:0] TYPE_CLOSE  = 3'd3;
   localparam logic [2:0] TYPE_PING   = 3'd4;
   localparam logic [2:0] TYPE_PONG   = 3'd5;
   localparam logic [2:0] TYPE_ERROR  = 3'd6;

   // opcodes of the first header byte
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // 7-bit length codes that select an extended length
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [2:0]  frame_type;
      logic [31:0] payload_length;
      logic        status_item;
   } rsp_type;

   // results of one parse step, in order: first, then second
   typedef struct packed {
      logic    first_valid;
      logic    second_valid;
      rsp_type first;
      rsp_type second;
   } push_type;

endpackage
`default_nettype wire

>>> rtl/websocket_frame_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_decoder_unit
// Parses one websocket frame per received buffer and unmasks its payload.
// ----------------------------------------------------------------------------
// The req channel carries one raw buffer byte per transaction, with
// buffer_end set on the last byte. The rsp channel returns each payload
// byte unmasked, then one status transaction (status_item set) carrying the
// frame type and payload length, or the error type. Payload bytes that came
// out before an error stand; drop them when the status reports an error.
// csr_wr_en writes payload_room, the destination capacity; write it only
// while no transaction is in flight.
// Each accepted byte is parsed from the input register into the result
// queue. Throughput is one byte per cycle while the queue has room, set by
// the single parse step between the input register and a four-entry result
// queue; the last byte of a buffer can push both a payload byte and the
// status. req_ready falls when the queue lacks room for two results, so a
// stalled receiver holds the input back after at most a few bytes.
// Reset clears the parse state and the queue and sets payload_room to all
// ones; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire wsfd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output wsfd_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [31:0]       csr_wr_data
);

   logic [31:0]        payload_room_ff, payload_room_in;
   logic               space_ok;
   wsfd_pkg::push_type push;

   assign payload_room_in = csr_wr_en ? csr_wr_data : payload_room_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_room_ff <= 32'hFFFF_FFFF;
      end else begin
         payload_room_ff <= payload_room_in;
      end
   end

   wsfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .payload_room (payload_room_ff),
      .space_ok     (space_ok),
      .push         (push)
   );

   wsfd_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> rtl/wsfd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_parser
// Input register and frame parse state; one byte per step, up to two results.
// ----------------------------------------------------------------------------
module wsfd_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire wsfd_pkg::req_type req_data,
   input  wire logic [31:0]       payload_room,
   input  wire logic              space_ok,
   output wsfd_pkg::push_type     push
);

   localparam logic [2:0] PH_FIRST   = 3'd0;
   localparam logic [2:0] PH_SECOND  = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_IGNORE  = 3'd5;

   logic              in_valid_ff, in_valid_in;
   wsfd_pkg::req_type in_data_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  hidx_ff, hidx_in;
   logic [2:0]  kind_ff, kind_in;
   logic        mask_ff, mask_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] count_ff, count_in;
   logic [1:0]  kpos_ff, kpos_in;
   logic        err_ff, err_in;

   logic fire;

   assign fire        = in_valid_ff && space_ok;
   assign req_ready   = !in_valid_ff || fire;
   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   always_comb begin
      logic [7:0]  b;
      logic [3:0]  op;
      logic [6:0]  l7;
      logic        len_done;
      logic        enter;
      logic        emit;
      logic [7:0]  k;
      logic [7:0]  pay;
      logic        ok;

      b        = in_data_ff.in_byte;
      op       = b[3:0];
      l7       = b[6:0];
      len_done = 1'b0;
      enter    = 1'b0;
      emit     = 1'b0;
      k        = 8'd0;
      pay      = 8'd0;
      ok       = 1'b0;

      phase_in = phase_ff;
      hidx_in  = hidx_ff;
      kind_in  = kind_ff;
      mask_in  = mask_ff;
      key_in   = key_ff;
      len_in   = len_ff;
      count_in = count_ff;
      kpos_in  = kpos_ff;
      err_in   = err_ff;

      case (phase_ff)
         PH_FIRST: begin
            phase_in = PH_SECOND;
            if (b[7]) begin
               case (op)
                  wsfd_pkg::OP_TEXT:   kind_in = wsfd_pkg::TYPE_TEXT;
                  wsfd_pkg::OP_BINARY: kind_in = wsfd_pkg::TYPE_BINARY;
                  wsfd_pkg::OP_CLOSE:  kind_in = wsfd_pkg::TYPE_CLOSE;
                  wsfd_pkg::OP_PING:   kind_in = wsfd_pkg::TYPE_PING;
                  wsfd_pkg::OP_PONG:   kind_in = wsfd_pkg::TYPE_PONG;
                  default: begin
                     err_in   = 1'b1;
                     phase_in = PH_IGNORE;
                  end
               endcase
            end else if (op == wsfd_pkg::OP_CONT) begin
               kind_in = wsfd_pkg::TYPE_CONT;
            end else begin
               err_in   = 1'b1;
               phase_in = PH_IGNORE;
            end
         end
         PH_SECOND: begin
            mask_in = b[7];
            len_in  = 32'd0;
            if (l7 == wsfd_pkg::LEN_EXT16) begin
               hidx_in  = 4'd2;
               phase_in = PH_EXTLEN;
            end else if (l7 == wsfd_pkg::LEN_EXT64) begin
               hidx_in  = 4'd8;
               phase_in = PH_EXTLEN;
            end else begin
               len_in   = {25'd0, l7};
               len_done = 1'b1;
            end
         end
         PH_EXTLEN: begin
            // upper four bytes of the 64-bit length must be zero
            if ((hidx_ff inside {[4'd5:4'd8]}) && (b != 8'd0)) begin
               err_in   = 1'b1;
               phase_in = PH_IGNORE;
            end else begin
               if (!(hidx_ff inside {[4'd5:4'd8]})) begin
                  len_in = {len_ff[23:0], b};
               end
               hidx_in = hidx_ff - 4'd1;
               if (hidx_in == 4'd0) begin
                  len_done = 1'b1;
               end
            end
         end
         PH_KEY: begin
            key_in[8*kpos_ff +: 8] = key_ff[8*kpos_ff +: 8] | b;
            kpos_in = kpos_ff + 2'd1;
            if (kpos_in == 2'd0) begin
               enter = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            if (mask_ff) begin
               k = key_ff[8*kpos_ff +: 8];
            end
            kpos_in  = kpos_ff + 2'd1;
            emit     = 1'b1;
            pay      = b ^ k;
            count_in = count_ff + 32'd1;
            if (count_in >= len_ff) begin
               phase_in = PH_IGNORE;
            end
         end
         default: begin
            phase_in = PH_IGNORE;
         end
      endcase

      if (len_done) begin
         // full-width room check: length + 1 > room
         if (({1'b0, len_in} + 33'd1) > {1'b0, payload_room}) begin
            err_in   = 1'b1;
            phase_in = PH_IGNORE;
         end else if (mask_in) begin
            kpos_in  = 2'd0;
            phase_in = PH_KEY;
         end else begin
            enter = 1'b1;
         end
      end

      if (enter) begin
         kpos_in  = 2'd0;
         phase_in = (len_in == 32'd0) ? PH_IGNORE : PH_PAYLOAD;
      end

      ok = (phase_in == PH_IGNORE) && !err_in;

      push = '0;
      if (fire) begin
         push.first_valid = emit || in_data_ff.buffer_end;
         push.second_valid = emit && in_data_ff.buffer_end;
      end
      push.first.out_byte       = emit ? pay : 8'd0;
      push.first.frame_type     = emit ? wsfd_pkg::TYPE_CONT
                                       : (ok ? kind_in : wsfd_pkg::TYPE_ERROR);
      push.first.payload_length = (emit || !ok) ? 32'd0 : len_in;
      push.first.status_item    = !emit;
      push.second.out_byte       = 8'd0;
      push.second.frame_type     = ok ? kind_in : wsfd_pkg::TYPE_ERROR;
      push.second.payload_length = ok ? len_in : 32'd0;
      push.second.status_item    = 1'b1;

      // end of buffer starts a fresh frame
      if (in_data_ff.buffer_end) begin
         phase_in = PH_FIRST;
         hidx_in  = 4'd0;
         kind_in  = 3'd0;
         mask_in  = 1'b0;
         key_in   = 32'd0;
         len_in   = 32'd0;
         count_in = 32'd0;
         kpos_in  = 2'd0;
         err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         hidx_ff  <= 4'd0;
         kind_ff  <= 3'd0;
         mask_ff  <= 1'b0;
         key_ff   <= 32'd0;
         len_ff   <= 32'd0;
         count_ff <= 32'd0;
         kpos_ff  <= 2'd0;
         err_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         hidx_ff  <= hidx_in;
         kind_ff  <= kind_in;
         mask_ff  <= mask_in;
         key_ff   <= key_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         kpos_ff  <= kpos_in;
         err_ff   <= err_in;
      end
   end

   a_push_needs_space : assert property (@(posedge clock) disable iff (reset)
      push.first_valid |-> space_ok)
      else $error("result pushed without queue space");

   a_end_restarts : assert property (@(posedge clock) disable iff (reset)
      (fire && in_data_ff.buffer_end) |=> (phase_ff == PH_FIRST) && !err_ff)
      else $error("parse state not cleared after end of buffer");

   a_error_ignores : assert property (@(posedge clock) disable iff (reset)
      err_ff |-> (phase_ff == PH_IGNORE))
      else $error("error flag set outside ignore phase");

endmodule
`default_nettype wire

>>> rtl/wsfd_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_out_queue
// Small result queue: two writes and one read per cycle.
// ----------------------------------------------------------------------------
module wsfd_out_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire wsfd_pkg::push_type push,
   output logic                    space_ok,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output wsfd_pkg::rsp_type       rsp_data
);

   localparam int unsigned PW = wsfd_pkg::QUEUE_PTR_W;
   localparam int unsigned CW = wsfd_pkg::QUEUE_CNT_W;

   wsfd_pkg::rsp_type slot_ff [wsfd_pkg::QUEUE_DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] wr_next;
   logic [CW-1:0] n_push;
   logic          pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   // room for a two-result step
   assign space_ok  = (count_ff <= CW'(wsfd_pkg::QUEUE_DEPTH - 2));

   assign wr_next   = wr_ptr_ff + PW'(1);
   assign n_push    = CW'(push.first_valid) + CW'(push.second_valid);
   assign wr_ptr_in = wr_ptr_ff + n_push[PW-1:0];
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + n_push - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.first_valid) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         slot_ff[wr_next] <= push.second;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(wsfd_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_second_after_first : assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> push.first_valid)
      else $error("second result without first");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Frame parsing and unmasking checks for websocket_frame_decoder_unit.
// ----------------------------------------------------------------------------
// Buffers go in one byte per transaction: a few hand-built frames first, then
// random frames. Most random frames are well formed, with a random opcode,
// mask and length form. The rest are cut short, corrupted, or plain noise.
// A scoreboard class keeps its own copy of the parse state, predicts the
// payload and status transactions for each byte sent, and compares them with
// what comes out in order. payload_room is changed between groups of buffers,
// and both sides stall at random, except in the last two groups.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned BYTES_PER_SETTING = 167;
   localparam logic [3:0] FRAME_OPS [6] = '{wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT,
                                           wsfd_pkg::OP_BINARY, wsfd_pkg::OP_CLOSE,
                                           wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG};

   typedef enum logic [2:0] {
      FIRST_HDR, SECOND_HDR, EXT_LEN, MASK_KEY, PAYLOAD, DISCARD
   } parse_phase_type;

   class frame_scoreboard_type;
      parse_phase_type   phase;
      logic [3:0]        ext_left;
      logic [2:0]        kind;
      logic              masked;
      logic [31:0]       key;
      logic [31:0]       length;
      logic [31:0]       count;
      logic [1:0]        key_pos;
      logic              bad;
      logic [31:0]       room;
      wsfd_pkg::rsp_type expected[$];
      int unsigned       mismatches;
      int unsigned       checked;
      int unsigned       status_seen;
      int unsigned       error_status;

      function new();
         room = '1;
         mismatches = 0;
         checked = 0;
         status_seen = 0;
         error_status = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         phase = FIRST_HDR;
         ext_left = '0;
         kind = '0;
         masked = 1'b0;
         key = '0;
         length = '0;
         count = '0;
         key_pos = '0;
         bad = 1'b0;
      endfunction

      function void flag_error();
         bad = 1'b1;
         phase = DISCARD;
      endfunction

      function void start_payload();
         key_pos = '0;
         phase = (length == 0) ? DISCARD : PAYLOAD;
      endfunction

      function void length_complete();
         // 33-bit compare so that length 0xffffffff cannot wrap
         if ({1'b0, length} + 33'd1 > {1'b0, room}) begin
            flag_error();
         end else if (masked) begin
            key_pos = '0;
            phase = MASK_KEY;
         end else begin
            start_payload();
         end
      endfunction

      // advance the parse state by one accepted byte, queue what it yields
      function void note_byte(wsfd_pkg::req_type item);
         wsfd_pkg::rsp_type r;
         logic              ok;
         logic [3:0]        op;
         logic [6:0]        len7;
         logic [7:0]        pad;
         r = '0;
         case (phase)
            FIRST_HDR: begin
               op = item.in_byte[3:0];
               phase = SECOND_HDR;
               if (item.in_byte[7]) begin
                  case (op)
                     wsfd_pkg::OP_TEXT:   kind = wsfd_pkg::TYPE_TEXT;
                     wsfd_pkg::OP_BINARY: kind = wsfd_pkg::TYPE_BINARY;
                     wsfd_pkg::OP_CLOSE:  kind = wsfd_pkg::TYPE_CLOSE;
                     wsfd_pkg::OP_PING:   kind = wsfd_pkg::TYPE_PING;
                     wsfd_pkg::OP_PONG:   kind = wsfd_pkg::TYPE_PONG;
                     default:             flag_error();
                  endcase
               end else if (op == wsfd_pkg::OP_CONT) begin
                  kind = wsfd_pkg::TYPE_CONT;
               end else begin
                  flag_error();
               end
            end
            SECOND_HDR: begin
               masked = item.in_byte[7];
               len7 = item.in_byte[6:0];
               length = '0;
               if (len7 == wsfd_pkg::LEN_EXT16) begin
                  ext_left = 4'd2;
                  phase = EXT_LEN;
               end else if (len7 == wsfd_pkg::LEN_EXT64) begin
                  ext_left = 4'd8;
                  phase = EXT_LEN;
               end else begin
                  length = {25'd0, len7};
                  length_complete();
               end
            end
            EXT_LEN: begin
               // upper four bytes of the 64-bit form must be zero
               if (ext_left > 4 && item.in_byte != 8'h00) begin
                  flag_error();
               end else begin
                  if (ext_left <= 4)
                     length = {length[23:0], item.in_byte};
                  ext_left = ext_left - 4'd1;
                  if (ext_left == 0)
                     length_complete();
               end
            end
            MASK_KEY: begin
               key[{key_pos, 3'b000} +: 8] = key[{key_pos, 3'b000} +: 8] | item.in_byte;
               key_pos = key_pos + 2'd1;
               if (key_pos == 0)
                  start_payload();
            end
            PAYLOAD: begin
               pad = masked ? key[{key_pos, 3'b000} +: 8] : 8'h00;
               key_pos = key_pos + 2'd1;
               r.out_byte = item.in_byte ^ pad;
               expected.push_back(r);
               count = count + 32'd1;
               if (count >= length)
                  phase = DISCARD;
            end
            default: begin
               phase = DISCARD;
            end
         endcase
         if (item.buffer_end) begin
            ok = (phase == DISCARD) && !bad;
            r = '0;
            r.frame_type = ok ? kind : wsfd_pkg::TYPE_ERROR;
            r.payload_length = ok ? length : 32'd0;
            r.status_item = 1'b1;
            expected.push_back(r);
            clear_frame();
         end
      endfunction

      function void compare_field(string field_name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field_name, want, got);
         end
      endfunction

      function void check_result(wsfd_pkg::rsp_type got);
         wsfd_pkg::rsp_type want;
         if (expected.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transaction, expected none, got %h", $time, got);
            return;
         end
         want = expected.pop_front();
         checked++;
         if (want.status_item) begin
            status_seen++;
            if (want.frame_type == wsfd_pkg::TYPE_ERROR)
               error_status++;
         end
         compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
         compare_field("frame_type", 32'(want.frame_type), 32'(got.frame_type));
         compare_field("payload_length", want.payload_length, got.payload_length);
         compare_field("status_item", 32'(want.status_item), 32'(got.status_item));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   wsfd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   wsfd_pkg::rsp_type rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [31:0]       csr_wr_data = '0;

   frame_scoreboard_type frames = new();
   logic [7:0]           frame_bytes[$];
   int unsigned          send_idle_pct = 0;
   int unsigned          recv_idle_pct = 0;
   int unsigned          bytes_sent = 0;
   int unsigned          buffers_sent = 0;
   int unsigned          quiet_cycles = 0;

   websocket_frame_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: check the transaction taken at this edge, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         frames.check_result(rsp_data);
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [7:0] header_byte(input logic fin, input logic [3:0] op);
      return {fin, 3'b000, op};
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic last);
      wsfd_pkg::req_type item;
      item.in_byte = value;
      item.buffer_end = last;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      frames.note_byte(item);
      bytes_sent++;
   endtask

   task automatic send_buffer();
      for (int i = 0; i < frame_bytes.size(); i++)
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      buffers_sent++;
   endtask

   // room changes only with nothing in flight
   task automatic write_room(input logic [31:0] value);
      req_valid <= 1'b0;
      while (frames.expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      frames.room = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic build_random_buffer();
      int unsigned pick;
      int unsigned form;
      int unsigned n_pay;
      int unsigned keep;
      logic [3:0]  op;
      logic [31:0] len;
      logic        masked;
      frame_bytes.delete();
      pick = $urandom_range(99);
      if (pick >= 88) begin
         repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(255)));
         return;
      end
      op = FRAME_OPS[$urandom_range(5)];
      if ($urandom_range(9) == 0)
         frame_bytes.push_back(8'($urandom_range(255)));
      else
         frame_bytes.push_back({op != wsfd_pkg::OP_CONT, 3'($urandom_range(7)), op});
      masked = 1'($urandom_range(1));
      form = $urandom_range(9);
      if (form < 6) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(125) : $urandom_range(12);
         frame_bytes.push_back({masked, len[6:0]});
      end else if (form < 9) begin
         len = ($urandom_range(5) == 0) ? $urandom_range(65535) : $urandom_range(20);
         frame_bytes.push_back({masked, wsfd_pkg::LEN_EXT16});
         frame_bytes.push_back(len[15:8]);
         frame_bytes.push_back(len[7:0]);
      end else begin
         len = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(20);
         frame_bytes.push_back({masked, wsfd_pkg::LEN_EXT64});
         repeat (4)
            frame_bytes.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'h00);
         frame_bytes.push_back(len[31:24]);
         frame_bytes.push_back(len[23:16]);
         frame_bytes.push_back(len[15:8]);
         frame_bytes.push_back(len[7:0]);
      end
      if (masked)
         repeat (4) frame_bytes.push_back(8'($urandom_range(255)));
      // long frames are cut short so the run stays short
      n_pay = (len > 40) ? $urandom_range(40) : len;
      repeat (n_pay) frame_bytes.push_back(8'($urandom_range(255)));
      if (len <= 40)
         repeat ($urandom_range(2)) frame_bytes.push_back(8'($urandom_range(255)));
      if (pick >= 76) begin
         if ($urandom_range(1)) begin
            keep = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > keep)
               void'(frame_bytes.pop_back());
         end else begin
            frame_bytes[$urandom_range(frame_bytes.size() - 1)] = 8'($urandom_range(255));
         end
      end
   endtask

   initial begin
      logic [31:0] room_settings [6];
      int unsigned phase_start;
      room_settings = '{32'd1, 32'($urandom_range(2, 24)), 32'hFFFF_FFFF,
                        $urandom_range(1, 32'hFFFF_FFFF), 32'd65536, 32'hFFFF_FFFF};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 27;
      recv_idle_pct = 46;
      write_room(32'hFFFF_FFFF);

      // buffer ends after one byte
      frame_bytes = '{header_byte(1'b1, wsfd_pkg::OP_TEXT)};
      send_buffer();
      // empty pong
      frame_bytes = '{header_byte(1'b1, wsfd_pkg::OP_PONG), 8'h00};
      send_buffer();
      // fin clear with a nonzero opcode
      frame_bytes = '{header_byte(1'b0, wsfd_pkg::OP_BINARY), 8'h00};
      send_buffer();
      // fin set with the continuation opcode
      frame_bytes = '{header_byte(1'b1, wsfd_pkg::OP_CONT), 8'h00};
      send_buffer();
      // unknown opcode, reserved bits set
      frame_bytes = '{8'hF3, 8'h00};
      send_buffer();
      // masked ping, one payload byte
      frame_bytes = '{header_byte(1'b1, wsfd_pkg::OP_PING), {1'b1, 7'd1},
                      8'hA5, 8'h5A, 8'hFF, 8'h00, 8'hFF};
      send_buffer();
      // close with a 16-bit length
      frame_bytes = '{header_byte(1'b1, wsfd_pkg::OP_CLOSE), {1'b0, wsfd_pkg::LEN_EXT16},
                      8'h00, 8'h01, 8'hFF};
      send_buffer();
      // nonzero upper length byte
      frame_bytes = '{header_byte(1'b1, wsfd_pkg::OP_BINARY), {1'b0, wsfd_pkg::LEN_EXT64},
                      8'h01};
      send_buffer();
      // continuation with a trailing byte
      frame_bytes = '{header_byte(1'b0, wsfd_pkg::OP_CONT), 8'h01, 8'h55, 8'hAA};
      send_buffer();

      for (int s = 0; s < 6; s++) begin
         case (s / 2)
            0: begin
               send_idle_pct = 27;
               recv_idle_pct = 46;
            end
            1: begin
               send_idle_pct = 46;
               recv_idle_pct = 27;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_room(room_settings[s]);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < BYTES_PER_SETTING) begin
            build_random_buffer();
            send_buffer();
         end
      end

      req_valid <= 1'b0;
      while (frames.expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d buffers (%0d bytes) under 7 room settings; checked %0d results",
               buffers_sent, bytes_sent, frames.checked);
      $display("%0d status transactions, %0d of them errors, %0d mismatches",
               frames.status_seen, frames.error_status, frames.mismatches);
      if (frames.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire

>>> websocket_frame_decoder_unit.f
rtl/wsfd_pkg.sv
rtl/wsfd_parser.sv
rtl/wsfd_out_queue.sv
rtl/websocket_frame_decoder_unit.sv
tb/testbench.sv
